### sv/next_fit_segment_allocator_top_assert.svh
`ifndef NEXT_FIT_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH
`define NEXT_FIT_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define NFSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NFSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/nfsa_pkg.sv
package nfsa_pkg;

  localparam int unsigned AddrW = 16;

  localparam logic [AddrW-1:0] POOL_BASE_RST = 16'h4000;
  localparam logic [AddrW-1:0] POOL_SIZE_RST = 16'hFFFF - POOL_BASE_RST + 16'd1;

  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOFIT    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic {
    REG_POOL_BASE = 1'b0,
    REG_POOL_SIZE = 1'b1
  } cfg_reg_e;

endpackage

### sv/nfsa_rec_mem.sv
module nfsa_rec_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 39
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### sv/nfsa_walker.sv
`include "next_fit_segment_allocator_top_assert.svh"

module nfsa_walker #(
  parameter int unsigned RECORDS = 64,
  parameter int unsigned IW      = $clog2(RECORDS),
  parameter int unsigned RW      = IW + 2 * nfsa_pkg::AddrW + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rebuild_i,
  input  nfsa_pkg::addr_t         pool_base_i,
  input  nfsa_pkg::addr_t         pool_size_i,
  input  logic                    s_tvalid_i,
  output logic                    s_tready_o,
  input  nfsa_pkg::kind_e         s_kind_i,
  input  nfsa_pkg::addr_t         s_len_i,
  input  nfsa_pkg::addr_t         s_faddr_i,
  output logic                    m_tvalid_o,
  input  logic                    m_tready_i,
  output nfsa_pkg::addr_t         m_addr_o,
  output nfsa_pkg::status_e       m_status_o,
  output logic                    idle_o,
  output logic                    mem_we_o,
  output logic [IW-1:0]           mem_waddr_o,
  output logic [RW-1:0]           mem_wdata_o,
  output logic [IW-1:0]           mem_raddr_o,
  input  logic [RW-1:0]           mem_rdata_i
);

  import nfsa_pkg::*;

  localparam int unsigned CW = $clog2(RECORDS + 1);

  typedef struct packed {
    logic          used;
    logic [IW-1:0] link;
    addr_t         length;
    addr_t         start;
  } rec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SPLIT,
    S_RESP
  } state_e;

  state_e        state_q;
  kind_e         kind_q;
  addr_t         len_q, faddr_q, start_q;
  logic [IW-1:0] p_q, cursor_q;
  logic [CW-1:0] steps_q, count_q;
  logic          fresh_q, sel0_q;
  addr_t         res_addr_q;
  status_e       res_st_q;
  logic          m_valid_q;
  addr_t         m_addr_q;
  status_e       m_st_q;

  rec_t          rec, wrec;
  logic          hit, exact, full, last;
  logic [CW-1:0] steps_nxt;
  addr_t         split_start, split_len;

  // entry 0 reads as the pool until first written after a rebuild
  always_comb begin
    if (sel0_q) begin
      rec.used   = 1'b0;
      rec.link   = '0;
      rec.length = pool_size_i;
      rec.start  = pool_base_i;
    end else begin
      rec = rec_t'(mem_rdata_i);
    end
  end

  assign hit         = (kind_q == KIND_FREE) ? (rec.start == faddr_q)
                                             : (!rec.used && (rec.length >= len_q));
  assign exact       = rec.length == len_q;
  assign full        = count_q >= CW'(RECORDS);
  assign steps_nxt   = steps_q + CW'(1);
  assign last        = steps_nxt == count_q;
  assign split_start = rec.start + len_q;
  assign split_len   = rec.length - len_q;

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = p_q;
    wrec        = rec;
    unique case (state_q)
      S_WALK: begin
        if (hit) begin
          if (kind_q == KIND_FREE) begin
            mem_we_o  = 1'b1;
            wrec.used = 1'b0;
          end else if (exact) begin
            mem_we_o  = 1'b1;
            wrec.used = 1'b1;
          end else if (!full) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = count_q[IW-1:0];
            wrec.used   = 1'b0;
            wrec.length = split_len;
            wrec.start  = split_start;
          end
        end
      end
      S_SPLIT: begin
        mem_we_o    = 1'b1;
        wrec.used   = 1'b1;
        wrec.link   = count_q[IW-1:0];
        wrec.length = len_q;
        wrec.start  = start_q;
      end
      default: ;
    endcase
  end

  assign mem_wdata_o = RW'(wrec);
  assign mem_raddr_o = (state_q == S_WALK) ? rec.link : cursor_q;

  assign s_tready_o  = state_q == S_IDLE;
  assign idle_o      = state_q == S_IDLE;
  assign m_tvalid_o  = m_valid_q;
  assign m_addr_o    = m_addr_q;
  assign m_status_o  = m_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      kind_q     <= KIND_ALLOC;
      len_q      <= '0;
      faddr_q    <= '0;
      start_q    <= '0;
      p_q        <= '0;
      cursor_q   <= '0;
      steps_q    <= '0;
      count_q    <= CW'(1);
      fresh_q    <= 1'b1;
      sel0_q     <= 1'b0;
      res_addr_q <= '0;
      res_st_q   <= STAT_OK;
      m_valid_q  <= 1'b0;
      m_addr_q   <= '0;
      m_st_q     <= STAT_OK;
    end else begin
      sel0_q <= fresh_q && (mem_raddr_o == '0);
      if (mem_we_o && (mem_waddr_o == '0)) begin
        fresh_q <= 1'b0;
      end
      if (m_valid_q && m_tready_i && (state_q != S_RESP)) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_tvalid_i) begin
            kind_q     <= s_kind_i;
            len_q      <= s_len_i;
            faddr_q    <= s_faddr_i;
            p_q        <= cursor_q;
            steps_q    <= '0;
            res_addr_q <= '0;
            if ((s_kind_i == KIND_ALLOC) && (s_len_i == '0)) begin
              res_st_q <= STAT_NOFIT;
              state_q  <= S_RESP;
            end else begin
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (hit) begin
            if (kind_q == KIND_FREE) begin
              cursor_q <= p_q;
              res_st_q <= STAT_OK;
              state_q  <= S_RESP;
            end else if (exact) begin
              cursor_q   <= rec.link;
              res_addr_q <= rec.start;
              res_st_q   <= STAT_OK;
              state_q    <= S_RESP;
            end else if (full) begin
              cursor_q <= p_q;
              res_st_q <= STAT_FULL;
              state_q  <= S_RESP;
            end else begin
              start_q <= rec.start;
              state_q <= S_SPLIT;
            end
          end else if (last) begin
            res_st_q <= (kind_q == KIND_FREE) ? STAT_NOTFOUND : STAT_NOFIT;
            state_q  <= S_RESP;
          end else begin
            p_q     <= rec.link;
            steps_q <= steps_nxt;
          end
        end
        S_SPLIT: begin
          cursor_q   <= p_q;
          count_q    <= count_q + CW'(1);
          res_addr_q <= start_q;
          res_st_q   <= STAT_OK;
          state_q    <= S_RESP;
        end
        S_RESP: begin
          if (!m_valid_q || m_tready_i) begin
            m_valid_q <= 1'b1;
            m_addr_q  <= res_addr_q;
            m_st_q    <= res_st_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (rebuild_i) begin
        fresh_q  <= 1'b1;
        cursor_q <= '0;
        count_q  <= CW'(1);
      end
    end
  end

  `NFSA_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, (count_q != '0) && (count_q <= CW'(RECORDS)), "record count out of range")
  `NFSA_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, s_tvalid_i && s_tready_o, state_q != S_IDLE, "accepted transaction not started")
  `NFSA_ASSERT_IMP(a_step_bound, clk_i, rst_ni, state_q == S_WALK, steps_q < count_q, "walk ran past the ring")
  `NFSA_ASSERT_IMP(a_write_busy, clk_i, rst_ni, mem_we_o, state_q != S_IDLE, "record write while idle")

endmodule

### sv/next_fit_segment_allocator_top.sv
// Result path: a zero-length allocate goes straight to the response state;
// any other request walks 1 to RECORDS ring records, adds a split state on
// a split, and loads the output register once an earlier result is taken.
// A new transaction is accepted only after that load; the walk reads one
// record a cycle from the single read port of the record memory.
// Reset (and any pool register write) leaves one free segment covering the
// pool, cursor at record 0; no clearing pass.
module next_fit_segment_allocator_top #(
  parameter int unsigned RECORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // request_length[15:0], free_address[31:16]
  input  logic [0:0]  s_axis_tuser_i,   // kind[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // granted_address[15:0], status[17:16], zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  import nfsa_pkg::*;

  localparam int unsigned IW = $clog2(RECORDS);
  localparam int unsigned RW = IW + 2 * AddrW + 1;

  addr_t         base_q, size_q;
  logic          cfg_wr;
  logic          idle, walk_ready;
  addr_t         m_addr;
  status_e       m_status;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [RW-1:0] mem_wdata, mem_rdata;

  // a pending register write takes priority over a new transaction
  assign cfg_ready_o     = idle;
  assign cfg_wr          = cfg_valid_i && idle;
  assign s_axis_tready_o = walk_ready && !cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= POOL_BASE_RST;
      size_q <= POOL_SIZE_RST;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_POOL_BASE: base_q <= cfg_data_i;
          REG_POOL_SIZE: size_q <= cfg_data_i;
        endcase
      end
    end
  end

  nfsa_rec_mem #(
    .Depth (RECORDS),
    .Width (RW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  nfsa_walker #(
    .RECORDS (RECORDS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rebuild_i   (cfg_wr),
    .pool_base_i (base_q),
    .pool_size_i (size_q),
    .s_tvalid_i  (s_axis_tvalid_i && !cfg_valid_i),
    .s_tready_o  (walk_ready),
    .s_kind_i    (kind_e'(s_axis_tuser_i[0])),
    .s_len_i     (s_axis_tdata_i[15:0]),
    .s_faddr_i   (s_axis_tdata_i[31:16]),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_addr_o    (m_addr),
    .m_status_o  (m_status),
    .idle_o      (idle),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign m_axis_tdata_o = {6'd0, m_status, m_addr};

endmodule
